@@ rtl/csdd_pkg.sv @@
// Shared types, constants and lookup tables for the charlieplexed display driver.
package csdd_pkg;

	localparam int NUM_PINS   = 7;
	localparam int NUM_DIGITS = 4;
	localparam int NUM_SEGS   = 7;
	localparam int NUM_GLYPHS = 19;
	localparam int NUM_DOTS   = 10;

	localparam logic [4:0] GLYPH_U     = 5'd16;
	localparam logic [4:0] GLYPH_BLANK = 5'd17;
	localparam logic [3:0] DOT_MAX     = 4'd9;
	localparam logic [7:0] VOL_MAX     = 8'd99;

	typedef enum logic [1:0] {
		CMD_DIGIT  = 2'd0,
		CMD_DOT    = 2'd1,
		CMD_SCAN   = 2'd2,
		CMD_VOLUME = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] position;
		logic [4:0] glyph;
		logic [7:0] volume;
		logic [3:0] dot_index;
		logic       dot_on;
	} item_t;

	// one byte per pin line; bit n set means pin n is pulled low while this line is high
	typedef logic [NUM_PINS-1:0][7:0] frame_t;

	// segment place: high nibble = line, low nibble = bit
	localparam logic [7:0] SEG_PLACE [NUM_DIGITS][NUM_SEGS] = '{
		'{8'h01, 8'h02, 8'h30, 8'h40, 8'h03, 8'h10, 8'h20},
		'{8'h12, 8'h13, 8'h41, 8'h15, 8'h14, 8'h21, 8'h31},
		'{8'h43, 8'h24, 8'h34, 8'h50, 8'h52, 8'h32, 8'h42},
		'{8'h65, 8'h56, 8'h45, 8'h53, 8'h35, 8'h54, 8'h46}
	};

	// segment patterns, bit 0 = a .. bit 6 = g
	localparam logic [NUM_SEGS-1:0] GLYPH_SEGS [NUM_GLYPHS] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h27, 7'h7F, 7'h67,
		7'h77, 7'h7D, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3E, 7'h00, 7'h40
	};

	// BT, SD, USB, REC, REP, three bars, colon, point
	localparam logic [7:0] DOT_PLACE [NUM_DOTS] = '{
		8'h05, 8'h51, 8'h25, 8'h04, 8'h62, 8'h06, 8'h16, 8'h36, 8'h17, 8'h40
	};

endpackage

@@ rtl/charlieplexed_segment_display_driver.sv @@
// A scan-tick beat passes through the input register, then the result register, before it
// appears on the master side. Digit, dot and volume beats update the frame buffer register
// as they leave the input register and produce no output beat.
// Throughput: one beat per cycle; a scan tick holds the input register only while an
// earlier result sits unaccepted in the result register.
// Reset (arst_n low): frame buffer blank, scan line 0, no beat held on either side.
module charlieplexed_segment_display_driver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // position[1:0], glyph[6:2], volume[14:7],
	                              // dot_index[18:15], dot_on[19], zero pad[23:20]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // line[2:0], high_mask[9:3], low_mask[16:10],
	                              // zero pad[23:17]
);
	import csdd_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	logic       is_scan;
	frame_t     frame;
	logic [2:0] line;
	logic [6:0] high_mask;
	logic [6:0] low_mask;

	// a scan tick can only leave the input register when the result slot is free or its result is being accepted
	assign is_scan  = (item_s1.cmd == CMD_SCAN);
	assign advance  = valid_s1 && (!is_scan || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd       <= cmd_t'(s_tuser);
			item_s1.position  <= s_tdata[1:0];
			item_s1.glyph     <= s_tdata[6:2];
			item_s1.volume    <= s_tdata[14:7];
			item_s1.dot_index <= s_tdata[18:15];
			item_s1.dot_on    <= s_tdata[19];
		end
	end

	// digit / volume / dot writes land in the frame buffer
	csdd_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (advance && !is_scan),
		.item   (item_s1),
		.frame  (frame)
	);

	// scan ticks read the current line and load the result register
	csdd_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_en   (advance && is_scan),
		.frame     (frame),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.line      (line),
		.high_mask (high_mask),
		.low_mask  (low_mask)
	);

	assign m_tdata = {7'd0, low_mask, high_mask, line};

endmodule

@@ rtl/csdd_frame.sv @@
// Frame buffer and its registered update for digit, volume and dot beats.
module csdd_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd_en,
	input  csdd_pkg::item_t  item,
	output csdd_pkg::frame_t frame
);
	import csdd_pkg::*;

	frame_t                   frame_q;
	frame_t                   frame_d;
	logic [NUM_DIGITS-1:0]    dig_wr;
	logic [NUM_SEGS-1:0]      dig_segs [NUM_DIGITS];
	logic [7:0]               place;
	logic [6:0]               vol_sat;
	logic [14:0]              vol_prod;
	logic [3:0]               tens;
	logic [3:0]               ones;
	logic [6:0]               tens_x10;
	logic [3:0]               dot_sel;

	// volume is at most 99, so x*205 >> 11 gives the tens digit exactly
	always_comb begin
		vol_sat  = (item.volume > VOL_MAX) ? VOL_MAX[6:0] : item.volume[6:0];
		vol_prod = 15'(vol_sat) * 15'd205;
		tens     = vol_prod[14:11];
		tens_x10 = 7'(tens) * 7'd10;
		ones     = 4'(vol_sat - tens_x10);
		dot_sel  = (item.dot_index > DOT_MAX) ? DOT_MAX : item.dot_index;
	end

	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			dig_wr[d]   = 1'b0;
			dig_segs[d] = '0;
		end
		case (item.cmd)
			CMD_DIGIT: begin
				for (int d = 0; d < NUM_DIGITS; d++) begin
					dig_wr[d]   = (32'(item.position) == d) && (32'(item.glyph) < NUM_GLYPHS);
					dig_segs[d] = GLYPH_SEGS[item.glyph];
				end
			end
			CMD_VOLUME: begin
				for (int d = 0; d < NUM_DIGITS; d++) begin
					dig_wr[d] = 1'b1;
					case (d)
						0:       dig_segs[d] = GLYPH_SEGS[GLYPH_BLANK];
						1:       dig_segs[d] = GLYPH_SEGS[GLYPH_U];
						2:       dig_segs[d] = GLYPH_SEGS[5'(tens)];
						default: dig_segs[d] = GLYPH_SEGS[5'(ones)];
					endcase
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		frame_d = frame_q;
		place   = '0;
		if (upd_en) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				for (int i = 0; i < NUM_SEGS; i++) begin
					if (dig_wr[d]) begin
						place = SEG_PLACE[d][i];
						frame_d[place[6:4]][place[2:0]] = dig_segs[d][i];
					end
				end
			end
			if (item.cmd == CMD_DOT) begin
				place = DOT_PLACE[dot_sel];
				frame_d[place[6:4]][place[2:0]] = item.dot_on;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else begin
			frame_q <= frame_d;
		end
	end

	assign frame = frame_q;

endmodule

@@ rtl/csdd_scan.sv @@
// Scan line counter, pin mask generation and the result register.
module csdd_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan_en,
	input  csdd_pkg::frame_t frame,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       line,
	output logic [6:0]       high_mask,
	output logic [6:0]       low_mask
);
	import csdd_pkg::*;

	logic [2:0] scan_q;
	logic [6:0] low_d;
	logic       valid_q;
	logic [2:0] line_q;
	logic [6:0] high_q;
	logic [6:0] low_q;

	// the scanned pin itself is never pulled low
	always_comb begin
		low_d = '0;
		for (int i = 0; i < NUM_PINS; i++) begin
			low_d[i] = frame[scan_q][i] && (32'(scan_q) != i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (scan_en) begin
				scan_q  <= (scan_q == 3'(NUM_PINS - 1)) ? 3'd0 : scan_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_en) begin
			line_q <= scan_q;
			high_q <= 7'd1 << scan_q;
			low_q  <= low_d;
		end
	end

	assign out_valid = valid_q;
	assign line      = line_q;
	assign high_mask = high_q;
	assign low_mask  = low_q;

endmodule

@@ test/tb_top.sv @@
// Testbench for the charlieplexed segment display driver: stream stimulus and pin-drive checks.
`timescale 1ns / 1ps

module tb_top;
	import csdd_pkg::*;

	// Idle cycles with no beat on either side before the run is called hung.
	// The longest legal quiet stretch is the receiver hold-off plus a few gaps.
	localparam int HANG_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BEATS = 1150;
	// Output beats lag their scan tick through the input and result registers; allow some slack at the end.
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_GLYPH_CODES = 19;

	// Own copies of the display wiring, taken from the behavior spec.
	// Segment place: high nibble = frame line, low nibble = bit.
	localparam logic [7:0] SEG_MAP [4][7] = '{
		'{8'h01, 8'h02, 8'h30, 8'h40, 8'h03, 8'h10, 8'h20},
		'{8'h12, 8'h13, 8'h41, 8'h15, 8'h14, 8'h21, 8'h31},
		'{8'h43, 8'h24, 8'h34, 8'h50, 8'h52, 8'h32, 8'h42},
		'{8'h65, 8'h56, 8'h45, 8'h53, 8'h35, 8'h54, 8'h46}
	};
	// Lit segments per glyph, bit 0 = a .. bit 6 = g.
	localparam logic [6:0] GLYPH_BITS [NUM_GLYPH_CODES] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h27, 7'h7F, 7'h67,
		7'h77, 7'h7D, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3E, 7'h00, 7'h40
	};
	// Indicator places: BT, SD, USB, REC, REP, three bars, colon, point.
	localparam logic [7:0] DOT_MAP [10] = '{
		8'h05, 8'h51, 8'h25, 8'h04, 8'h62, 8'h06, 8'h16, 8'h36, 8'h17, 8'h40
	};

	typedef struct {
		logic [2:0] line;
		logic [6:0] high;
		logic [6:0] low;
	} pin_drive_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // position[1:0], glyph[6:2], volume[14:7], dot_index[18:15],
	                        // dot_on[19], zero pad[23:20]
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // line[2:0], high_mask[9:3], low_mask[16:10], zero pad[23:17]

	charlieplexed_segment_display_driver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Tracks the frame buffer and scan line, and holds the pin drives still owed.
	class drive_tracker;
		logic [7:0] lit_lines [NUM_PINS];
		logic [2:0] scan_pos;
		pin_drive_t drive_due [$];
		int         fault_count;

		function new();
			foreach (lit_lines[i]) lit_lines[i] = '0;
			scan_pos    = '0;
			fault_count = 0;
		endfunction

		function void set_place(logic [7:0] place, logic on);
			lit_lines[place[6:4]][place[2:0]] = on;
		endfunction

		// Out-of-range glyph or position leaves the buffer untouched.
		function void paint_digit(int pos, int code);
			logic [6:0] segs;
			if (code >= NUM_GLYPH_CODES || pos >= NUM_DIGITS)
				return;
			segs = GLYPH_BITS[code];
			for (int i = 0; i < 7; i++)
				set_place(SEG_MAP[pos][i], segs[i]);
		endfunction

		// Decodes an accepted input beat straight from the bus layout.
		function void take_beat(cmd_t cmd, logic [19:0] d);
			logic [7:0] vol;
			logic [3:0] idx;
			pin_drive_t drv;
			vol = d[14:7];
			idx = d[18:15];
			case (cmd)
				CMD_DIGIT: begin
					paint_digit(int'(d[1:0]), int'(d[6:2]));
				end
				CMD_DOT: begin
					if (idx > 4'd9)
						idx = 4'd9;
					set_place(DOT_MAP[idx], d[19]);
				end
				CMD_VOLUME: begin
					if (vol > 8'd99)
						vol = 8'd99;
					paint_digit(0, int'(GLYPH_BLANK));
					paint_digit(1, int'(GLYPH_U));
					paint_digit(2, int'(vol) / 10);
					paint_digit(3, int'(vol) % 10);
				end
				default: begin
					// scan tick: own pin never pulled low, pins past the top never driven
					drv.line = scan_pos;
					drv.high = 7'(1 << scan_pos);
					drv.low  = '0;
					for (int i = 0; i < NUM_PINS && i < 7; i++)
						if (i != int'(scan_pos) && lit_lines[scan_pos][i])
							drv.low[i] = 1'b1;
					drive_due.push_back(drv);
					scan_pos = (int'(scan_pos) + 1 >= NUM_PINS) ? 3'd0 : scan_pos + 3'd1;
				end
			endcase
		endfunction

		task report_fault(string what, int got, int want);
			fault_count++;
			$display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
		endtask

		task check_drive(logic [23:0] q);
			pin_drive_t drv;
			if (drive_due.size() == 0) begin
				report_fault("unexpected output beat", int'(q), 0);
				return;
			end
			drv = drive_due.pop_front();
			if (q[2:0] !== drv.line)
				report_fault("line", int'(q[2:0]), int'(drv.line));
			if (q[9:3] !== drv.high)
				report_fault("high_mask", int'(q[9:3]), int'(drv.high));
			if (q[16:10] !== drv.low)
				report_fault("low_mask", int'(q[16:10]), int'(drv.low));
			if (q[23:17] !== 7'd0)
				report_fault("tdata pad", int'(q[23:17]), 0);
		endtask

		function int pending();
			return drive_due.size();
		endfunction

		task close_out();
			if (drive_due.size() != 0)
				report_fault("missing output beats", 0, drive_due.size());
		endtask
	endclass

	drive_tracker tracker = new();

	// Sender pacing; burst stretches send back to back.
	int sent_count = 0;
	bit send_burst = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [19:0] pack_fields(logic [1:0] pos, logic [4:0] glyph,
	                                            logic [7:0] vol, logic [3:0] idx, logic on);
		return {on, idx, vol, glyph, pos};
	endfunction

	// Offers one beat after a drawn gap and returns once it is taken.
	// Valid stays high across back-to-back beats, so it is only lowered for a real gap.
	task automatic push_beat(cmd_t cmd, logic [19:0] d);
		int gap;
		if (sent_count % 40 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'd0, d};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_beat(cmd, d);
		sent_count++;
	endtask

	// Random beat: every field random regardless of command, scans frequent
	// so the frame buffer is read back often.
	task automatic push_random();
		int         pick;
		cmd_t       cmd;
		logic [4:0] glyph;
		logic [7:0] vol;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			cmd = CMD_SCAN;
		else if (pick < 70)
			cmd = CMD_DIGIT;
		else if (pick < 85)
			cmd = CMD_DOT;
		else
			cmd = CMD_VOLUME;
		glyph = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, 18)) : 5'($urandom);
		vol   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 99)) : 8'($urandom);
		push_beat(cmd, pack_fields(2'($urandom), glyph, vol, 4'($urandom), 1'($urandom)));
	endtask

	// Main sequence: reset, directed beats, random beats, drain, verdict.
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= CMD_DIGIT;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blank frame seen on line 0
		push_beat(CMD_SCAN,   pack_fields(2'd0, 5'd0,  8'd0,   4'd0,  1'b0));
		// full glyph, dash, two ignored glyph codes, extremes of position
		push_beat(CMD_DIGIT,  pack_fields(2'd0, 5'd8,  8'd0,   4'd0,  1'b0));
		push_beat(CMD_DIGIT,  pack_fields(2'd1, 5'd18, 8'hFF,  4'hF,  1'b1));
		push_beat(CMD_DIGIT,  pack_fields(2'd2, 5'd31, 8'd0,   4'd0,  1'b0));
		push_beat(CMD_DIGIT,  pack_fields(2'd3, 5'd19, 8'd0,   4'd0,  1'b0));
		push_beat(CMD_DIGIT,  pack_fields(2'd3, 5'd0,  8'd0,   4'd0,  1'b0));
		push_beat(CMD_DIGIT,  pack_fields(2'd2, 5'd15, 8'd0,   4'd0,  1'b0));
		// dots: lowest, highest on, then off through a clamped index, colon
		push_beat(CMD_DOT,    pack_fields(2'd0, 5'd0,  8'd0,   4'd0,  1'b1));
		push_beat(CMD_DOT,    pack_fields(2'd3, 5'd31, 8'hFF,  4'd9,  1'b1));
		push_beat(CMD_DOT,    pack_fields(2'd0, 5'd0,  8'd0,   4'd15, 1'b0));
		push_beat(CMD_DOT,    pack_fields(2'd0, 5'd0,  8'd0,   4'd8,  1'b1));
		// one full scan cycle over all lines, plus wrap
		repeat (8)
			push_beat(CMD_SCAN, pack_fields(2'd3, 5'd31, 8'hFF, 4'hF, 1'b1));
		// volume: zero, saturated, just above the limit, at the limit
		push_beat(CMD_VOLUME, pack_fields(2'd0, 5'd0,  8'd0,   4'd0,  1'b0));
		push_beat(CMD_VOLUME, pack_fields(2'd0, 5'd0,  8'd255, 4'd0,  1'b0));
		push_beat(CMD_VOLUME, pack_fields(2'd0, 5'd0,  8'd100, 4'd0,  1'b0));
		push_beat(CMD_SCAN,   pack_fields(2'd0, 5'd0,  8'd0,   4'd0,  1'b0));
		push_beat(CMD_VOLUME, pack_fields(2'd0, 5'd0,  8'd99,  4'd0,  1'b0));
		push_beat(CMD_SCAN,   pack_fields(2'd0, 5'd0,  8'd0,   4'd0,  1'b0));

		repeat (RANDOM_BEATS)
			push_random();
		s_tvalid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: draws a wait per beat, with back-to-back stretches, and twice
	// holds off long enough that the result register fills and s_tready drops.
	initial begin
		int taken;
		int gap;
		bit recv_burst;
		taken      = 0;
		recv_burst = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 32 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			gap = recv_burst ? 0 : $urandom_range(0, 14);
			if (taken == 60 || taken == 200)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Output monitor: values read at the edge are the ones the edge sampled.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_drive(m_tdata);
	end

	// Hang watchdog: quiet cycles on both sides.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= HANG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
rtl/csdd_pkg.sv
rtl/csdd_frame.sv
rtl/csdd_scan.sv
rtl/charlieplexed_segment_display_driver.sv
test/tb_top.sv
